>>> src/cbd_pkg.sv
// shared types, constants and the hex digit decode function of the chunked body decoder
`default_nettype none

package cbd_pkg;

    // default width of the chunk size counter
    localparam int CBD_SIZE_BITS = 24;

    // ascii codes of the line terminator
    localparam logic [7:0] CHR_CR = 8'h0d;
    localparam logic [7:0] CHR_LF = 8'h0a;

    // ascii ranges of hex digits
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_LOW_F = 8'h66;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_F  = 8'h46;

    // bytes skipped after the data of a chunk
    localparam logic [1:0] SKIP_COUNT = 2'd2;

    // decoder phase
    typedef enum logic [2:0] {
        PH_DIGITS = 3'd0,
        PH_LINE   = 3'd1,
        PH_DATA   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    // result kind
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_DATA  = 3'd1,
        K_DONE  = 3'd2,
        K_OVER  = 3'd3,
        K_TRUNC = 3'd4
    } t_kind;

    // one input request as held in the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_req;

    // one result as produced by the step logic
    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
    } t_result;

    // hex digit decode
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex       h;
        logic [7:0] diff;
        h    = '{valid: 1'b0, value: 4'd0};
        diff = 8'd0;
        if (c >= CHR_0 && c <= CHR_9) begin
            diff    = c - CHR_0;
            h.valid = 1'b1;
            h.value = diff[3:0];
        end else if (c >= CHR_LOW_A && c <= CHR_LOW_F) begin
            diff    = c - CHR_LOW_A + 8'd10;
            h.valid = 1'b1;
            h.value = diff[3:0];
        end else if (c >= CHR_UP_A && c <= CHR_UP_F) begin
            diff    = c - CHR_UP_A + 8'd10;
            h.valid = 1'b1;
            h.value = diff[3:0];
        end
        return h;
    endfunction

endpackage

`default_nettype wire

>>> src/cbd_if.sv
// valid/ready channel interfaces for raw input bytes and decoded results
`default_nettype none

interface cbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_body;

    modport source (output valid, output in_byte, output end_of_body, input ready);
    modport sink   (input valid, input in_byte, input end_of_body, output ready);
endinterface

interface cbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;

    modport source (output valid, output out_byte, output kind, input ready);
    modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

`default_nettype wire

>>> src/cbd_core.sv
// decoder state registers and the single-pass step logic for one byte
`default_nettype none

module cbd_core
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = CBD_SIZE_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_in_req i_req,
    output t_result      o_result
);

    t_phase               r_phase,       n_phase;
    logic [SIZE_BITS-1:0] r_chunk_count, n_chunk_count;
    logic                 r_saw_digit,   n_saw_digit;
    logic                 r_prev_was_cr, n_prev_was_cr;
    logic [1:0]           r_skip_left,   n_skip_left;

    t_hex                 hex;
    logic [SIZE_BITS-1:0] count_dec;
    logic                 is_crlf;

    assign hex       = hex_decode(i_req.in_byte);
    assign count_dec = r_chunk_count - {{(SIZE_BITS-1){1'b0}}, 1'b1};
    assign is_crlf   = (i_req.in_byte == CHR_LF) && r_prev_was_cr;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_DIGITS;
            r_chunk_count <= '0;
            r_saw_digit   <= 1'b0;
            r_prev_was_cr <= 1'b0;
            r_skip_left   <= 2'd0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_chunk_count <= n_chunk_count;
            r_saw_digit   <= n_saw_digit;
            r_prev_was_cr <= n_prev_was_cr;
            r_skip_left   <= n_skip_left;
        end
    end

    // next state and result for the byte in the input register
    always_comb begin
        n_phase       = r_phase;
        n_chunk_count = r_chunk_count;
        n_saw_digit   = r_saw_digit;
        n_prev_was_cr = r_prev_was_cr;
        n_skip_left   = r_skip_left;
        o_result      = '{out_byte: 8'd0, kind: K_NONE};

        unique case (r_phase)
            PH_DIGITS, PH_LINE: begin
                if (r_phase == PH_DIGITS && hex.valid) begin
                    // another size digit, unless the top nibble is already used
                    if (r_chunk_count[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_phase       = PH_DONE;
                        o_result.kind = K_OVER;
                    end else begin
                        n_chunk_count = {r_chunk_count[SIZE_BITS-5:0], hex.value};
                        n_saw_digit   = 1'b1;
                    end
                end else begin
                    // rest of the size line up to cr lf
                    n_phase = PH_LINE;
                    if (is_crlf) begin
                        n_prev_was_cr = 1'b0;
                        if (!r_saw_digit || r_chunk_count == '0) begin
                            n_phase       = PH_DONE;
                            o_result.kind = K_DONE;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_prev_was_cr = (i_req.in_byte == CHR_CR);
                    end
                end
            end
            PH_DATA: begin
                o_result.kind     = K_DATA;
                o_result.out_byte = i_req.in_byte;
                n_chunk_count     = count_dec;
                if (count_dec == '0) begin
                    n_phase     = PH_SKIP;
                    n_skip_left = SKIP_COUNT;
                end
            end
            PH_SKIP: begin
                n_skip_left = r_skip_left - 2'd1;
                if (n_skip_left == 2'd0) begin
                    n_phase       = PH_DIGITS;
                    n_chunk_count = '0;
                    n_saw_digit   = 1'b0;
                    n_prev_was_cr = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // end of body: report truncation and rearm
        if (i_req.last) begin
            if (n_phase != PH_DONE) begin
                o_result = '{out_byte: 8'd0, kind: K_TRUNC};
            end
            n_phase       = PH_DIGITS;
            n_chunk_count = '0;
            n_saw_digit   = 1'b0;
            n_prev_was_cr = 1'b0;
            n_skip_left   = 2'd0;
        end
    end

endmodule

`default_nettype wire

>>> src/chunked_body_decoder_top.sv
// chunked body decoder: input register, step logic and result register
// an accepted request passes the input register, then the result register
// throughput: one byte per cycle while the result register is free or drains
// every accepted byte gives exactly one result, kind 0 included
// synchronous active-low reset returns the decoder to the size digits phase
// and empties both the input and the result register
`default_nettype none

module chunked_body_decoder_top
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = CBD_SIZE_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbd_in_if.sink    i_in,
    cbd_out_if.source o_out
);

    logic       r_in_valid;
    t_in_req    r_in_req;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_result;
    logic       step;

    // the held byte moves on when the result register is free or drains
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_req <= '{in_byte: i_in.in_byte, last: i_in.end_of_body};
        end
    end

    // decoder state and step logic
    cbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_req    (r_in_req),
        .o_result (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out.out_byte;
    assign o_out.kind     = r_out.kind;

endmodule

`default_nettype wire
